/* design/lvr_pkg.sv */
// Shared constants and types for the longest vertical run block.
`timescale 1ns / 1ps

package lvr_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int LANES      = 8;
  localparam int ROWS       = MAX_WIDTH / LANES;
  localparam int POS_W      = $clog2(ROWS);
  localparam int BPR_W      = POS_W + 1;
  localparam int WIDTH_W    = 13;
  localparam int RUN_W      = 13;
  localparam int BEST_W     = 14;
  localparam int WORD_W     = LANES * RUN_W;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_RUN_POLARITY = 1'b1;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(MAX_WIDTH);
  localparam logic [RUN_W-1:0]   RUN_SAT     = RUN_W'(MAX_HEIGHT);
  localparam logic signed [BEST_W-1:0] NO_RUN = -14'sd1;

  typedef struct packed {
    logic hit;
    logic [RUN_W-1:0] run;
  } lane_res_t;

  typedef struct packed {
    logic last;
    logic first_row;
    logic polarity;
    logic [LANES-1:0] in_range;
    logic [POS_W-1:0] addr;
  } s1_ctl_t;

endpackage

/* design/lvr_lane.sv */
// One column lane: updates the run length of a single column.
`timescale 1ns / 1ps

module lvr_lane (
  input  logic pix,
  input  logic polarity,
  input  logic in_range,
  input  logic first_row,
  input  logic [lvr_pkg::RUN_W-1:0] old_run,
  output logic [lvr_pkg::RUN_W-1:0] new_run,
  output lvr_pkg::lane_res_t res
);
  import lvr_pkg::*;

  logic match;
  logic [RUN_W:0] inc;
  logic [RUN_W-1:0] run;

  always_comb begin
    match = (pix == polarity);
    inc   = {1'b0, old_run} + {{RUN_W{1'b0}}, 1'b1};
    if (!match) begin
      run = '0;
    end else if (first_row) begin
      run = RUN_W'(1);
    end else if (inc > {1'b0, RUN_SAT}) begin
      run = RUN_SAT;
    end else begin
      run = inc[RUN_W-1:0];
    end
    // columns past the width keep whatever they held
    new_run = in_range ? run : old_run;
    res.hit = in_range && match;
    res.run = run;
  end

endmodule

/* design/lvr_merge.sv */
// Merge stage: maximum over the lanes and the running best of the image.
`timescale 1ns / 1ps

module lvr_merge (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic last,
  input  lvr_pkg::lane_res_t lanes [lvr_pkg::LANES],
  output logic signed [lvr_pkg::BEST_W-1:0] best_next
);
  import lvr_pkg::*;

  logic signed [BEST_W-1:0] best;
  logic signed [BEST_W-1:0] l0 [LANES];
  logic signed [BEST_W-1:0] l1 [LANES/2];
  logic signed [BEST_W-1:0] l2 [LANES/4];
  logic signed [BEST_W-1:0] cand;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      l0[i] = lanes[i].hit ? $signed({1'b0, lanes[i].run}) : NO_RUN;
    end
    for (int i = 0; i < LANES/2; i++) begin
      l1[i] = (l0[2*i] > l0[2*i+1]) ? l0[2*i] : l0[2*i+1];
    end
    for (int i = 0; i < LANES/4; i++) begin
      l2[i] = (l1[2*i] > l1[2*i+1]) ? l1[2*i] : l1[2*i+1];
    end
    cand      = (l2[0] > l2[1]) ? l2[0] : l2[1];
    best_next = (cand > best) ? cand : best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best <= NO_RUN;
    end else if (adv) begin
      // start afresh once the image is reported
      best <= last ? NO_RUN : best_next;
    end
  end

endmodule

/* design/longest_vertical_run.sv */
// Top level: longest vertical run over a packed bitonal image.
//
//   channel  signals                          direction
//   input    in_valid in_stall pixel_byte last_byte   into the block
//   output   out_valid out_stall longest_run           out of the block
//   config   cfg_write cfg_index cfg_data             into the block
//
// One pixel byte a cycle while in_stall is low; a result is registered into
// longest_run as its last byte leaves stage one. Each byte reads one row of
// column counts (eight lanes) from the count memory and writes it back from
// stage one; a bypass covers one-byte rows. Reset clears control state only;
// the count memory needs no clearing, since an image's first row never uses it.
// The input stalls only while a finished result waits on a stalled output.
`timescale 1ns / 1ps

module longest_vertical_run (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] pixel_byte,
  input  logic last_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [lvr_pkg::BEST_W-1:0] longest_run,
  input  logic cfg_write,
  input  logic cfg_index,
  input  logic [lvr_pkg::WIDTH_W-1:0] cfg_data
);
  import lvr_pkg::*;

  logic [WIDTH_W-1:0] image_width;
  logic run_polarity;

  logic [POS_W-1:0] pos;
  logic first_row;

  logic [WIDTH_W-1:0] w_eff;
  logic [WIDTH_W:0] w_sum;
  logic [BPR_W-1:0] bpr;
  logic row_end;
  logic [LANES-1:0] in_range;
  logic acc;

  logic [WORD_W-1:0] mem [ROWS];
  logic s1_valid;
  s1_ctl_t s1_ctl;
  logic [7:0] s1_pix;
  logic [WORD_W-1:0] rd_data;
  logic byp;
  logic [WORD_W-1:0] byp_data;
  logic [WORD_W-1:0] old_word;
  logic [WORD_W-1:0] new_word;
  logic adv;
  lane_res_t lane_res [LANES];
  logic signed [BEST_W-1:0] best_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      run_polarity <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_RUN_POLARITY: run_polarity <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (image_width > WIDTH_RESET) begin
      w_eff = WIDTH_RESET;
    end else begin
      w_eff = image_width;
    end
    w_sum   = {1'b0, w_eff} + (WIDTH_W + 1)'(LANES - 1);
    bpr     = w_sum[$clog2(LANES) +: BPR_W];
    row_end = ({1'b0, pos} + BPR_W'(1)) >= bpr;
    for (int b = 0; b < LANES; b++) begin
      in_range[b] = {1'b0, pos, 3'(b)} < w_eff;
    end
  end

  assign in_stall = s1_valid && s1_ctl.last && out_valid && out_stall;
  assign acc      = in_valid && !in_stall;
  assign adv      = s1_valid && !(s1_ctl.last && out_valid && out_stall);

  // byte position within the row
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      first_row <= 1'b1;
    end else if (acc) begin
      if (last_byte) begin
        pos       <= '0;
        first_row <= 1'b1;
      end else if (row_end) begin
        pos       <= '0;
        first_row <= 1'b0;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv || !s1_valid) begin
      s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ctl.last      <= last_byte;
      s1_ctl.first_row <= first_row;
      s1_ctl.polarity  <= run_polarity;
      s1_ctl.in_range  <= in_range;
      s1_ctl.addr      <= pos;
      s1_pix           <= pixel_byte;
      rd_data          <= mem[pos];
      // the row being written back this edge is not yet in the memory
      byp              <= adv && (s1_ctl.addr == pos);
      byp_data         <= new_word;
    end
    if (adv) begin
      mem[s1_ctl.addr] <= new_word;
    end
  end

  assign old_word = byp ? byp_data : rd_data;

  for (genvar b = 0; b < LANES; b++) begin : g_lane
    lvr_lane u_lane (
      .pix       (s1_pix[LANES-1-b]),
      .polarity  (s1_ctl.polarity),
      .in_range  (s1_ctl.in_range[b]),
      .first_row (s1_ctl.first_row),
      .old_run   (old_word[b*RUN_W +: RUN_W]),
      .new_run   (new_word[b*RUN_W +: RUN_W]),
      .res       (lane_res[b])
    );
  end

  lvr_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .last      (s1_ctl.last),
    .lanes     (lane_res),
    .best_next (best_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s1_ctl.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_ctl.last) begin
      longest_run <= best_next;
    end
  end

  a_stall_only_on_held_last: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_ctl.last && !adv))
    else $error("input stalled without a held last word");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (longest_run >= NO_RUN && longest_run <= $signed({1'b0, RUN_SAT})))
    else $error("result out of range");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (acc && last_byte) |=> (pos == '0 && first_row && s1_valid && s1_ctl.last))
    else $error("image did not restart after last word");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_ctl.last) |=> out_valid)
    else $error("last word left no result");

endmodule

/* bench/tb.sv */
// Self-checking bench for longest_vertical_run: random packed images against a run-length predictor.
`timescale 1ns / 1ps

module tb;
  import lvr_pkg::*;

  localparam int CYCLE_LIMIT = 100000;

  typedef struct packed {
    logic [7:0] pix;
    logic       eoi;
  } byte_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] pixel_byte = 8'h00;
  logic last_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [BEST_W-1:0] longest_run;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_IMAGE_WIDTH;
  logic [WIDTH_W-1:0] cfg_data = '0;

  longest_vertical_run dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pixel_byte(pixel_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall), .longest_run(longest_run),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  byte_word_t pending_bytes[$];
  logic signed [BEST_W-1:0] expected_runs[$];
  int errors = 0;
  int cycles = 0;

  // Predictor state: shadow registers and per-column run counts
  logic [WIDTH_W-1:0] width_reg;
  logic               polarity_reg;
  logic [RUN_W-1:0]   col_run [0:MAX_WIDTH-1];
  int                 byte_pos;
  bit                 first_row;
  int                 best;

  function automatic void scan_byte(input logic [7:0] pix, input logic eoi);
    int w;
    int bpr;
    int col;
    int run;
    bit hit;
    w = int'(width_reg);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    bpr = (w + 7) / 8;
    for (int b = 0; b < 8; b++) begin
      col = byte_pos * 8 + b;
      hit = (pix[7-b] == polarity_reg);
      // padding past the image width
      if (col >= w) continue;
      if (!hit) run = 0;
      else if (first_row) run = 1;
      else begin
        run = int'(col_run[col]) + 1;
        if (run > MAX_HEIGHT) run = MAX_HEIGHT;
      end
      col_run[col] = RUN_W'(run);
      if (hit && run > best) best = run;
    end
    if (byte_pos + 1 >= bpr) begin
      byte_pos = 0;
      first_row = 1'b0;
    end else begin
      byte_pos = byte_pos + 1;
    end
    if (eoi) begin
      expected_runs.push_back(BEST_W'(best));
      byte_pos = 0;
      first_row = 1'b1;
      best = -1;
    end
  endfunction

  // Driver: one word from the pending queue at a time, with a drawn gap after each
  byte_word_t next_word;
  int gap_left = 0;
  bit calm_in = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_bytes.size() != 0) begin
        next_word = pending_bytes.pop_front();
        pixel_byte <= next_word.pix;
        last_byte <= next_word.eoi;
        in_valid <= 1'b1;
        if ($urandom_range(0, 29) == 0) calm_in = !calm_in;
        gap_left <= calm_in ? 0 : $urandom_range(0, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: each result waits a drawn number of cycles once it shows
  int hold_left = 0;
  int hold_draw;
  bit calm_out = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && !out_stall) begin
      if ($urandom_range(0, 9) == 0) calm_out = !calm_out;
      hold_draw = calm_out ? 0 : $urandom_range(0, 8);
      hold_left <= hold_draw;
      out_stall <= (hold_draw != 0);
    end else if (out_valid && hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end
  end

  // Monitor: track register writes, predict on accepted bytes, check accepted results
  logic signed [BEST_W-1:0] want;

  always @(posedge clk) begin
    if (rst) begin
      width_reg = WIDTH_RESET;
      polarity_reg = 1'b1;
      byte_pos = 0;
      first_row = 1'b1;
      best = -1;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data;
        else polarity_reg = cfg_data[0];
      end
      if (in_valid && !in_stall) scan_byte(pixel_byte, last_byte);
      if (out_valid && !out_stall) begin
        if (expected_runs.size() == 0) begin
          $error("longest_run: no result expected, got %0d", longest_run);
          errors++;
        end else begin
          want = expected_runs.pop_front();
          if (longest_run !== want) begin
            $error("longest_run: expected %0d, got %0d", want, longest_run);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic queue_word(input logic [7:0] pix, input logic eoi);
    byte_word_t w;
    w.pix = pix;
    w.eoi = eoi;
    pending_bytes.push_back(w);
  endtask

  // Wait until every byte is in and every result out, then let the pipeline drain
  task automatic settle();
    while (pending_bytes.size() != 0 || in_valid || expected_runs.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= WIDTH_W'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    int sent;
    int w;
    int bpr;
    int rows;
    int total;
    int fill;
    logic [7:0] pix;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: full width, set pixels; image ends inside its first row
    queue_word(8'hFF, 1'b0);
    queue_word(8'h00, 1'b0);
    queue_word(8'h81, 1'b1);
    settle();

    // Width zero acts as one column; padding bits ignored
    write_reg(REG_IMAGE_WIDTH, 0);
    queue_word(8'h80, 1'b0);
    queue_word(8'hBF, 1'b0);
    queue_word(8'h7F, 1'b0);
    queue_word(8'h80, 1'b1);
    settle();

    // Clear pixels counted, none present: no run at all
    write_reg(REG_RUN_POLARITY, 0);
    write_reg(REG_IMAGE_WIDTH, 9);
    queue_word(8'hFF, 1'b0);
    queue_word(8'hFF, 1'b1);
    settle();

    // Width above the maximum clamps to the maximum
    write_reg(REG_IMAGE_WIDTH, 8191);
    queue_word(8'h00, 1'b1);
    settle();

    // Width shrinks mid-image: the rest of the row is dropped
    write_reg(REG_RUN_POLARITY, 1);
    write_reg(REG_IMAGE_WIDTH, 24);
    repeat (4) queue_word(8'hFF, 1'b0);
    settle();
    write_reg(REG_IMAGE_WIDTH, 8);
    queue_word(8'hFF, 1'b0);
    queue_word(8'hFF, 1'b1);
    settle();

    // Full width, clear pixels counted: a short image inside the first row
    write_reg(REG_IMAGE_WIDTH, MAX_WIDTH);
    write_reg(REG_RUN_POLARITY, 0);
    for (int i = 0; i < 4; i++) queue_word(8'($urandom & $urandom), i == 3);
    settle();
    w = MAX_WIDTH;

    sent = 0;
    while (sent < 550) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        case ($urandom_range(0, 11))
          0: w = 0;
          1: w = 8191;
          2, 3: w = $urandom_range(1, 8);
          4: w = $urandom_range(41, 200);
          default: w = $urandom_range(1, 40);
        endcase
        write_reg(REG_IMAGE_WIDTH, w);
      end
      if ($urandom_range(0, 3) == 0) begin
        settle();
        write_reg(REG_RUN_POLARITY, $urandom_range(0, 1));
      end
      bpr = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH / 8 : (w + 7) / 8;
      rows = $urandom_range(1, 6);
      total = rows * bpr;
      // cut some images short, and keep wide ones brief
      if (total > 64 || $urandom_range(0, 3) == 0)
        total = $urandom_range(1, (total > 64) ? 64 : total);
      fill = $urandom_range(0, 2);
      for (int n = 1; n <= total; n++) begin
        pix = 8'($urandom);
        if (fill == 1) pix = pix | 8'($urandom) | 8'($urandom);
        else if (fill == 2) pix = pix & 8'($urandom) & 8'($urandom);
        queue_word(pix, n == total);
      end
      sent += total;
    end

    settle();
    repeat (10) @(negedge clk);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
